[rtl/sspc_pkg.sv]
package sspc_pkg;

  localparam int unsigned MAX_ECHO_BYTES = 38;

  localparam int unsigned ECHO_W = 6;
  localparam int unsigned ADDR_W = 4;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ECHO    = 3'd1,
    PH_HEADER  = 3'd2,
    PH_ERROR   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TIMEOUT    = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_ID_MISMATCH = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_TOO_LONG   = 3'd5,
    ST_CHECKSUM   = 3'd6,
    ST_SERVO_ERROR = 3'd7
  } status_t;

  localparam logic [1:0] REG_EXPECTED_ID     = 2'd0;
  localparam logic [1:0] REG_MAX_PAYLOAD_LEN = 2'd1;
  localparam logic [1:0] REG_ECHO_SKIP_COUNT = 2'd2;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0] ERROR_MASK    = 8'h7F;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;

  localparam logic [7:0] RESET_EXPECTED_ID     = 8'd1;
  localparam logic [7:0] RESET_MAX_PAYLOAD_LEN = 8'd32;

  typedef struct packed {
    logic       is_final;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    status_t    status;
    logic [7:0] servo_error;
  } result_t;

endpackage

[rtl/servo_status_packet_checker_top.sv]
// A result word is registered and appears on the master side in the cycle after its input word is taken.
// Throughput: one input word per cycle; the input is stalled only while a result word
// waits in the single output register and the master side is not ready.
// Reset: synchronous, active high; clears parser state, output valid and restores
// register defaults (expected_id 1, max_payload_len 32, echo_skip_count 0).
module servo_status_packet_checker_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // rx_byte
  input  logic [1:0]                  s_axis_tuser,  // action
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // payload_byte[7:0], payload_index[15:8], status[18:16], servo_error[26:19], zero[31:27]
  output logic [31:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,  // is_final
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sspc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sspc_pkg::*;

  logic [7:0]        expected_id;
  logic [7:0]        max_payload_len;
  logic [ECHO_W-1:0] echo_skip_count;

  phase_t            phase, phase_next;
  logic [ECHO_W-1:0] echo_left, echo_left_next;
  logic [1:0]        header_pos, header_pos_next;
  logic              preamble_ok, preamble_ok_next;
  logic [7:0]        header_id, header_id_next;
  logic [7:0]        payload_left, payload_left_next;
  logic [7:0]        payload_count, payload_count_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        error_seen, error_seen_next;

  logic              res_valid;
  result_t           res;
  result_t           out_reg;

  logic              in_fire;
  logic              cfg_write;
  logic              busy;
  action_t           action;
  logic [7:0]        rx_byte;
  logic [7:0]        len_payload;
  logic [7:0]        sum_plus;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id     <= RESET_EXPECTED_ID;
      max_payload_len <= RESET_MAX_PAYLOAD_LEN;
      echo_skip_count <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_EXPECTED_ID:     expected_id     <= pwdata[7:0];
        REG_MAX_PAYLOAD_LEN: max_payload_len <= pwdata[7:0];
        REG_ECHO_SKIP_COUNT: echo_skip_count <= pwdata[ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EXPECTED_ID:     prdata = {24'd0, expected_id};
      REG_MAX_PAYLOAD_LEN: prdata = {24'd0, max_payload_len};
      REG_ECHO_SKIP_COUNT: prdata = {{(32-ECHO_W){1'b0}}, echo_skip_count};
      default:             prdata = '0;
    endcase
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign action        = action_t'(s_axis_tuser);
  assign rx_byte       = s_axis_tdata;
  assign busy          = (phase != PH_IDLE) && (phase != PH_DONE);
  assign len_payload   = rx_byte - MIN_LENGTH;
  assign sum_plus      = running_sum + rx_byte;

  always_comb begin
    phase_next         = phase;
    echo_left_next     = echo_left;
    header_pos_next    = header_pos;
    preamble_ok_next   = preamble_ok;
    header_id_next     = header_id;
    payload_left_next  = payload_left;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    error_seen_next    = error_seen;
    res_valid          = 1'b0;
    res.is_final       = 1'b1;
    res.payload_byte   = '0;
    res.payload_index  = payload_count;
    res.status         = ST_OK;
    res.servo_error    = error_seen;

    case (action)
      ACT_START: begin
        if ({2'b00, echo_skip_count} > 8'(MAX_ECHO_BYTES)) begin
          echo_left_next = ECHO_W'(MAX_ECHO_BYTES);
        end else begin
          echo_left_next = echo_skip_count;
        end
        phase_next         = (echo_left_next != '0) ? PH_ECHO : PH_HEADER;
        header_pos_next    = '0;
        preamble_ok_next   = 1'b1;
        header_id_next     = '0;
        payload_left_next  = '0;
        payload_count_next = '0;
        running_sum_next   = '0;
        error_seen_next    = '0;
      end
      ACT_TIMEOUT: begin
        if (busy) begin
          res_valid  = 1'b1;
          res.status = ST_TIMEOUT;
          phase_next = PH_DONE;
        end
      end
      ACT_BYTE: begin
        case (phase)
          PH_ECHO: begin
            echo_left_next = echo_left - 1'b1;
            if (echo_left_next == '0) begin
              phase_next = PH_HEADER;
            end
          end
          PH_HEADER: begin
            if (header_pos < 2'd2) begin
              if (rx_byte != PREAMBLE_BYTE) begin
                preamble_ok_next = 1'b0;
              end
              header_pos_next = header_pos + 1'b1;
            end else if (header_pos == 2'd2) begin
              header_id_next  = rx_byte;
              header_pos_next = 2'd3;
            end else if (!preamble_ok) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_HEADER;
              phase_next = PH_DONE;
            end else if (header_id != expected_id) begin
              res_valid  = 1'b1;
              res.status = ST_ID_MISMATCH;
              phase_next = PH_DONE;
            end else if (rx_byte < MIN_LENGTH) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_LENGTH;
              phase_next = PH_DONE;
            end else if (len_payload > max_payload_len) begin
              res_valid  = 1'b1;
              res.status = ST_TOO_LONG;
              phase_next = PH_DONE;
            end else begin
              payload_left_next  = len_payload;
              payload_count_next = '0;
              running_sum_next   = header_id + rx_byte;
              phase_next         = PH_ERROR;
            end
          end
          PH_ERROR: begin
            error_seen_next  = rx_byte;
            running_sum_next = sum_plus;
            phase_next       = (payload_left != '0) ? PH_PAYLOAD : PH_CHECK;
          end
          PH_PAYLOAD: begin
            res_valid          = 1'b1;
            res.is_final       = 1'b0;
            res.payload_byte   = rx_byte;
            running_sum_next   = sum_plus;
            payload_count_next = payload_count + 1'b1;
            payload_left_next  = payload_left - 1'b1;
            if (payload_left_next == '0) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res_valid  = 1'b1;
            phase_next = PH_DONE;
            if (~running_sum != rx_byte) begin
              res.status = ST_CHECKSUM;
            end else if ((error_seen & ERROR_MASK) != '0) begin
              res.status = ST_SERVO_ERROR;
            end else begin
              res.status = ST_OK;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      echo_left     <= '0;
      header_pos    <= '0;
      preamble_ok   <= 1'b1;
      header_id     <= '0;
      payload_left  <= '0;
      payload_count <= '0;
      running_sum   <= '0;
      error_seen    <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      echo_left     <= echo_left_next;
      header_pos    <= header_pos_next;
      preamble_ok   <= preamble_ok_next;
      header_id     <= header_id_next;
      payload_left  <= payload_left_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      error_seen    <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {5'd0, out_reg.servo_error, out_reg.status,
                         out_reg.payload_index, out_reg.payload_byte};
  assign m_axis_tuser = out_reg.is_final;

  a_final_ends_reply: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid && res.is_final) |=> (phase == PH_DONE))
    else $error("final result did not end the reply");

  a_payload_from_payload_phase: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid && !res.is_final) |-> (phase == PH_PAYLOAD))
    else $error("payload result outside payload phase");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_idle_is_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (payload_count == '0 && echo_left == '0))
    else $error("idle phase with stale counters");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sspc_pkg::*;

  localparam int RANDOM_WORDS = 1320;
  localparam int ROUND_WORDS = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    RK_GOOD,
    RK_BAD_PREAMBLE,
    RK_BAD_ID,
    RK_BAD_LEN,
    RK_TOO_LONG,
    RK_BAD_SUM,
    RK_TIMEOUT,
    RK_RESTART,
    RK_NOISE
  } reply_kind_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // rx_byte
  logic [1:0]          s_axis_tuser;   // action
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // payload_byte[7:0], payload_index[15:8], status[18:16], servo_error[26:19], zero[31:27]
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tuser;   // is_final
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  servo_status_packet_checker_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  logic [7:0] cfg_id = RESET_EXPECTED_ID;
  logic [7:0] cfg_max_len = RESET_MAX_PAYLOAD_LEN;
  logic [5:0] cfg_echo = '0;

  phase_t     ph = PH_IDLE;
  logic [5:0] echo_left = '0;
  logic [1:0] hdr_pos = '0;
  logic       pre_ok = 1'b1;
  logic [7:0] hdr_id = '0;
  logic [7:0] pay_left = '0;
  logic [7:0] pay_cnt = '0;
  logic [7:0] run_sum = '0;
  logic [7:0] srv_err = '0;

  result_t expected_results[$];
  int      taken_words = 0;
  int      error_count = 0;
  int      stall_cycles = 0;
  bit      idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void finish_reply(status_t st);
    result_t r;
    r.is_final      = 1'b1;
    r.payload_byte  = '0;
    r.payload_index = pay_cnt;
    r.status        = st;
    r.servo_error   = srv_err;
    expected_results.push_back(r);
    ph = PH_DONE;
  endfunction

  function automatic bit parse_word(action_t act, logic [7:0] b);
    result_t    r;
    bit         busy;
    logic [5:0] n;
    busy = (ph != PH_IDLE) && (ph != PH_DONE);
    if (act == ACT_START) begin
      n = (cfg_echo > MAX_ECHO_BYTES) ? 6'(MAX_ECHO_BYTES) : cfg_echo;
      echo_left = n;
      ph        = (n != 0) ? PH_ECHO : PH_HEADER;
      hdr_pos   = '0;
      pre_ok    = 1'b1;
      hdr_id    = '0;
      pay_left  = '0;
      pay_cnt   = '0;
      run_sum   = '0;
      srv_err   = '0;
      return 1'b1;
    end
    if (!busy || act == ACT_UNUSED) return 1'b0;
    if (act == ACT_TIMEOUT) begin
      finish_reply(ST_TIMEOUT);
      return 1'b1;
    end
    case (ph)
      PH_ECHO: begin
        echo_left = echo_left - 6'd1;
        if (echo_left == 0) ph = PH_HEADER;
      end
      PH_HEADER: begin
        if (hdr_pos < 2) begin
          if (b != PREAMBLE_BYTE) pre_ok = 1'b0;
          hdr_pos = hdr_pos + 2'd1;
        end else if (hdr_pos == 2) begin
          hdr_id  = b;
          hdr_pos = 2'd3;
        end else if (!pre_ok) begin
          finish_reply(ST_BAD_HEADER);
        end else if (hdr_id != cfg_id) begin
          finish_reply(ST_ID_MISMATCH);
        end else if (b < MIN_LENGTH) begin
          finish_reply(ST_BAD_LENGTH);
        end else if (8'(b - MIN_LENGTH) > cfg_max_len) begin
          finish_reply(ST_TOO_LONG);
        end else begin
          pay_left = b - MIN_LENGTH;
          pay_cnt  = '0;
          run_sum  = hdr_id + b;
          ph       = PH_ERROR;
        end
      end
      PH_ERROR: begin
        srv_err = b;
        run_sum = run_sum + b;
        ph      = (pay_left != 0) ? PH_PAYLOAD : PH_CHECK;
      end
      PH_PAYLOAD: begin
        r.is_final      = 1'b0;
        r.payload_byte  = b;
        r.payload_index = pay_cnt;
        r.status        = ST_OK;
        r.servo_error   = srv_err;
        expected_results.push_back(r);
        run_sum  = run_sum + b;
        pay_cnt  = pay_cnt + 8'd1;
        pay_left = pay_left - 8'd1;
        if (pay_left == 0) ph = PH_CHECK;
      end
      PH_CHECK: begin
        if (8'(~run_sum) != b) finish_reply(ST_CHECKSUM);
        else if ((srv_err & ERROR_MASK) != 0) finish_reply(ST_SERVO_ERROR);
        else finish_reply(ST_OK);
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  task automatic send_word(input action_t act, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (parse_word(act, b)) taken_words++;
  endtask

  task automatic send_header(input logic [7:0] id, input logic [7:0] len);
    send_word(ACT_START, 8'($urandom));
    send_word(ACT_BYTE, PREAMBLE_BYTE);
    send_word(ACT_BYTE, PREAMBLE_BYTE);
    send_word(ACT_BYTE, id);
    send_word(ACT_BYTE, len);
  endtask

  task automatic settle;
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_EXPECTED_ID:     cfg_id = val[7:0];
      REG_MAX_PAYLOAD_LEN: cfg_max_len = val[7:0];
      REG_ECHO_SKIP_COUNT: cfg_echo = val[5:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_reply(input reply_kind_t kind);
    logic [7:0] stream[$];
    logic [7:0] len;
    logic [7:0] err;
    logic [7:0] sum;
    logic [7:0] b;
    int         plen;
    int         n_echo;
    int         cut;
    int         limit;
    bit         hdr_kind;
    if (kind == RK_NOISE) begin
      repeat ($urandom_range(1, 6)) send_word(action_t'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    hdr_kind = kind inside {RK_BAD_PREAMBLE, RK_BAD_ID, RK_BAD_LEN, RK_TOO_LONG};
    n_echo = (cfg_echo > MAX_ECHO_BYTES) ? MAX_ECHO_BYTES : int'(cfg_echo);
    limit = (cfg_max_len < 12) ? int'(cfg_max_len) : 12;
    if ($urandom_range(0, 39) == 0) limit = int'(cfg_max_len);
    plen = $urandom_range(0, limit);
    len = 8'(plen + 2);
    case ($urandom_range(0, 7))
      0, 1: err = 8'($urandom);
      2:    err = 8'h80;
      default: err = 8'h00;
    endcase
    repeat (n_echo) stream.push_back(8'($urandom));
    stream.push_back(PREAMBLE_BYTE);
    stream.push_back(PREAMBLE_BYTE);
    if (kind == RK_BAD_PREAMBLE) stream[n_echo + $urandom_range(0, 1)] = 8'($urandom_range(0, 254));
    stream.push_back((kind == RK_BAD_ID) ? (cfg_id ^ 8'($urandom_range(1, 255))) : cfg_id);
    if (kind == RK_BAD_LEN) len = 8'($urandom_range(0, 1));
    if (kind == RK_TOO_LONG && cfg_max_len < 253)
      len = 8'($urandom_range(int'(cfg_max_len) + 3, 255));
    stream.push_back(len);
    sum = cfg_id + len + err;
    stream.push_back(err);
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      stream.push_back(b);
      sum = sum + b;
    end
    sum = ~sum;
    if (kind == RK_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    stream.push_back(sum);
    cut = stream.size();
    if (kind == RK_TIMEOUT || kind == RK_RESTART) cut = $urandom_range(0, stream.size() - 1);
    else if (hdr_kind) cut = n_echo + 4;
    send_word(ACT_START, 8'($urandom));
    for (int i = 0; i < cut; i++) send_word(ACT_BYTE, stream[i]);
    if (kind == RK_TIMEOUT) send_word(ACT_TIMEOUT, 8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      send_word(ACT_BYTE, 8'($urandom));
      send_word(ACT_TIMEOUT, 8'($urandom));
    end
  endtask

  function automatic reply_kind_t pick_kind;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return RK_GOOD;
    if (r < 65) return RK_BAD_PREAMBLE;
    if (r < 70) return RK_BAD_ID;
    if (r < 74) return RK_BAD_LEN;
    if (r < 78) return RK_TOO_LONG;
    if (r < 84) return RK_BAD_SUM;
    if (r < 90) return RK_TIMEOUT;
    if (r < 95) return RK_RESTART;
    return RK_NOISE;
  endfunction

  task automatic test_ignored_words;
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_TIMEOUT, 8'h00);
    send_word(ACT_UNUSED, 8'hA5);
  endtask

  task automatic test_good_reply;
    send_header(8'd1, 8'd5);
    send_word(ACT_BYTE, 8'h80);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_UNUSED, 8'h5A);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h3C);
    send_word(ACT_BYTE, ~(8'd1 + 8'd5 + 8'h80 + 8'h00 + 8'hFF + 8'h3C));
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_TIMEOUT, 8'h00);
  endtask

  task automatic test_header_checks;
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h7F);
    send_word(ACT_BYTE, 8'h09);
    send_word(ACT_BYTE, 8'h00);
    send_header(8'd0, 8'd0);
    send_header(8'd1, 8'd1);
    send_header(8'd1, 8'd35);
  endtask

  task automatic test_timeout_and_restart;
    send_header(8'd1, 8'd34);
    send_word(ACT_BYTE, 8'h02);
    send_word(ACT_BYTE, 8'h11);
    send_word(ACT_TIMEOUT, 8'hFF);
    send_word(ACT_START, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_header(8'd1, 8'd2);
    send_word(ACT_BYTE, 8'h01);
    send_word(ACT_BYTE, ~(8'd1 + 8'd2 + 8'h01));
  endtask

  task automatic test_checksum_order;
    send_header(8'd1, 8'd2);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h00);
  endtask

  task automatic test_random;
    int round;
    int base;
    int stop_at;
    round = 0;
    base = taken_words;
    while (taken_words < base + RANDOM_WORDS) begin
      settle;
      case (round)
        0: begin
          write_reg(REG_EXPECTED_ID, 32'd0);
          write_reg(REG_MAX_PAYLOAD_LEN, 32'd0);
          write_reg(REG_ECHO_SKIP_COUNT, 32'd0);
        end
        1: begin
          write_reg(REG_EXPECTED_ID, 32'd255);
          write_reg(REG_MAX_PAYLOAD_LEN, 32'd253);
          write_reg(REG_ECHO_SKIP_COUNT, 32'd38);
        end
        2: begin
          write_reg(REG_EXPECTED_ID, $urandom_range(0, 255));
          write_reg(REG_MAX_PAYLOAD_LEN, 32'd5);
          write_reg(REG_ECHO_SKIP_COUNT, 32'd63);
        end
        default: begin
          write_reg(REG_EXPECTED_ID, $urandom_range(0, 255));
          case ($urandom_range(0, 3))
            0: write_reg(REG_MAX_PAYLOAD_LEN, $urandom_range(0, 3));
            1: write_reg(REG_MAX_PAYLOAD_LEN, $urandom_range(0, 20));
            2: write_reg(REG_MAX_PAYLOAD_LEN, 32'd253);
            default: write_reg(REG_MAX_PAYLOAD_LEN, $urandom_range(0, 253));
          endcase
          case ($urandom_range(0, 3))
            0: write_reg(REG_ECHO_SKIP_COUNT, 32'd0);
            1: write_reg(REG_ECHO_SKIP_COUNT, $urandom_range(39, 63));
            default: write_reg(REG_ECHO_SKIP_COUNT, $urandom_range(0, 8));
          endcase
        end
      endcase
      idle_on = (taken_words < base + RANDOM_WORDS * 4 / 5) && (round % 4 != 3);
      stop_at = taken_words + ROUND_WORDS;
      while (taken_words < stop_at) send_reply(pick_kind());
      round++;
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: tuser %0h tdata %0h", m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.is_final) begin
          $error("is_final: expected %0h, got %0h", want.is_final, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[7:0] !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, m_axis_tdata[7:0]);
          error_count++;
        end
        if (m_axis_tdata[15:8] !== want.payload_index) begin
          $error("payload_index: expected %0d, got %0d", want.payload_index,
                 m_axis_tdata[15:8]);
          error_count++;
        end
        if (m_axis_tdata[18:16] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[18:16]);
          error_count++;
        end
        if (m_axis_tdata[26:19] !== want.servo_error) begin
          $error("servo_error: expected %0h, got %0h", want.servo_error, m_axis_tdata[26:19]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_START;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_ignored_words;
    test_good_reply;
    test_header_checks;
    test_timeout_and_restart;
    test_checksum_order;
    test_random;
    idle_on = 1'b0;
    settle;
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sspc_pkg.sv
rtl/servo_status_packet_checker_top.sv
dv/tb.sv
